// File: design/rrt_pkg.sv
// ----------------------------------------------------------------------------
// rrt_pkg
// Shared types, codes and helpers for the 2-D tree extension block.
// ----------------------------------------------------------------------------
package rrt_pkg;

  // default sizes of the node table, obstacle table and steering steps
  localparam int MaxNodesDef     = 64;
  localparam int MaxObstaclesDef = 16;
  localparam int MaxStepsDef     = 64;

  // path results per extend request
  localparam int ResultCap = 64;

  // iteration counts of the square root and of each divide
  localparam int SqIters  = 25;
  localparam int DivBits  = 48;

  localparam int CoordW = 24;
  localparam int LenW   = 23;
  localparam int CfgW   = 24;

  typedef enum logic [1:0] {
    REQ_CLEAR   = 2'd0,
    REQ_APPEND  = 2'd1,
    REQ_RESTART = 2'd2,
    REQ_EXTEND  = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_ACK      = 3'd0,
    ST_REJECT   = 3'd1,
    ST_ADDED    = 3'd2,
    ST_PATH     = 3'd3,
    ST_FAILED   = 3'd4,
    ST_FULL     = 3'd5,
    ST_FINISHED = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    CFG_START_X   = 3'd0,
    CFG_START_Y   = 3'd1,
    CFG_GOAL_X    = 3'd2,
    CFG_GOAL_Y    = 3'd3,
    CFG_EXPAND    = 3'd4,
    CFG_STEP_LEN  = 3'd5,
    CFG_ITER_LIM  = 3'd6
  } cfg_reg_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_NEAR_RD, S_NEAR_MX, S_NEAR_MY, S_NEAR_CMP,
    S_D2X, S_D2Y, S_D2S, S_SQRT,
    S_DIVL, S_LIM,
    S_SXM, S_SXL, S_DIVX,
    S_SYM, S_SYL, S_DIVY, S_SFIN,
    S_STEP,
    S_OB_RD, S_OB_MX, S_OB_MY, S_OB_MR, S_OB_CMP,
    S_DECIDE,
    S_G2X, S_G2Y, S_G2R, S_G2CMP,
    S_FAIL,
    S_PATH_RD, S_PATH_OUT
  } state_t;

  // signed difference of two coordinates, one bit wider
  function automatic logic signed [CoordW:0] sdiff(input logic [CoordW-1:0] a,
                                                   input logic [CoordW-1:0] b);
    sdiff = signed'({a[CoordW-1], a}) - signed'({b[CoordW-1], b});
  endfunction

  // magnitude of a difference, unsigned
  function automatic logic [CoordW:0] mag(input logic signed [CoordW:0] d);
    mag = d[CoordW] ? (CoordW+1)'(-d) : d;
  endfunction

  // clamp a grown sum to the coordinate range
  function automatic logic [CoordW-1:0] sat(input logic [CoordW+1:0] s);
    if (s[CoordW+1] == s[CoordW] && s[CoordW] == s[CoordW-1]) begin
      sat = s[CoordW-1:0];
    end else if (s[CoordW+1]) begin
      sat = {1'b1, {(CoordW-1){1'b0}}};
    end else begin
      sat = {1'b0, {(CoordW-1){1'b1}}};
    end
  endfunction

endpackage

// File: design/rrt_tree_extend_2d_core.sv
// ----------------------------------------------------------------------------
// rrt_tree_extend_2d_core
// Grows a 2-D RRT tree by one node per sample, reached in steering steps,
// with obstacle checks and path readout back to the start once the goal radius is reached.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries req_type, point_x, point_y and
//   radius. A transfer happens when in_valid is high and in_stall is low.
//   Output channel (out_valid/out_stall) carries status, out_x, out_y and
//   last; last marks the final result of one request.
//   Clear, append and restart requests and extends while finished give one
//   result in the cycle after their transfer.
//   An extend walks the node table (read, two squares and a compare per node),
//   takes a square root and a divide, and where the step count is not zero
//   two more divides, then runs each steering step (a move, then per obstacle
//   a read, three squares and a compare until a hit). All of this goes
//   through one multiplier, one square root step and one divide step.
//   Path readout reads and then emits each point.
//   in_stall stays high while a request is in progress; the last result
//   waits in the output register, and the next request is taken no earlier
//   than the edge at which that result transfers.
//   A stalled receiver holds the output register and, where more results
//   follow, the sequencer.
//   Synchronous reset empties the node and obstacle tables, marks planning
//   finished and loads the register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module rrt_tree_extend_2d_core #(
  parameter int MAX_NODES     = rrt_pkg::MaxNodesDef,
  parameter int MAX_OBSTACLES = rrt_pkg::MaxObstaclesDef,
  parameter int MAX_STEPS     = rrt_pkg::MaxStepsDef
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [23:0] point_x,
  input  logic [23:0] point_y,
  input  logic [22:0] radius,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [23:0] out_x,
  output logic [23:0] out_y,
  output logic        last
);

  localparam int CW  = rrt_pkg::CoordW;
  localparam int LW  = rrt_pkg::LenW;
  localparam int NIW = $clog2(MAX_NODES);
  localparam int NTW = $clog2(MAX_NODES + 1);
  localparam int OIW = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
  localparam int OTW = $clog2(MAX_OBSTACLES + 1);
  localparam int SW  = $clog2(MAX_STEPS + 1);
  localparam int DB  = rrt_pkg::DivBits;
  localparam int PW  = 2 * (CW + 1);
  localparam int CNW = $clog2(DB);

  // configuration registers
  logic [CW-1:0] start_x, start_y, goal_x, goal_y;
  logic [LW-1:0] expand_limit, step_length;
  logic [5:0]    iteration_limit;

  // tables
  logic [CW-1:0]  node_x   [MAX_NODES];
  logic [CW-1:0]  node_y   [MAX_NODES];
  logic [NIW-1:0] node_par [MAX_NODES];
  logic [CW-1:0]  obs_x    [MAX_OBSTACLES];
  logic [CW-1:0]  obs_y    [MAX_OBSTACLES];
  logic [LW-1:0]  obs_r    [MAX_OBSTACLES];

  logic [NTW-1:0] node_total;
  logic [OTW-1:0] obs_total;
  logic [5:0]     extend_count;
  logic           plan_finished;

  // sequencer and datapath registers
  rrt_pkg::state_t state, state_next;
  logic [NIW-1:0] scan_idx, near_idx;
  logic [OIW-1:0] obs_idx;
  logic [CW-1:0]  rd_x, rd_y, ob_x, ob_y;
  logic [NIW-1:0] rd_par;
  logic [LW-1:0]  ob_r;
  logic [CW-1:0]  px, py, bx, by, cx, cy;
  logic signed [CW:0] dx, dy, sx, sy;
  logic [PW-1:0]  prod;
  logic [PW:0]    acc, best;
  logic [PW-1:0]  sq_v, sq_r, sq_bit;
  logic [CW:0]    d_val;
  logic [DB-1:0]  div_num;
  logic [CW+1:0]  div_rem;
  logic [CW:0]    div_den;
  logic [CNW-1:0] cnt;
  logic [SW-1:0]  steps, k;
  logic [5:0]     pcnt;
  logic           blocked;

  // output register
  logic [2:0]    out_status;
  logic [CW-1:0] out_xr, out_yr;
  logic          out_last;

  // combinational control
  logic          out_free, in_take, emit, e_last;
  rrt_pkg::status_t e_st;
  logic [CW-1:0] e_x, e_y;
  logic [CW:0]   mul_a, mul_b;
  logic [LW-1:0] res;
  logic          fail, scan_last, obs_last, steps_done, path_end;
  logic [PW:0]   sum2;
  logic [PW-1:0] sq_t, sq_r_new, sq_v_new;
  logic [CW+1:0] rem_sh;
  logic          div_ge;
  logic [DB-1:0] div_num_new;
  logic [SW-1:0] lim_steps;
  logic [CW:0]   div_q;
  logic [CW:0]   lim_src;

  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = !(state == rrt_pkg::S_IDLE && out_free);
  assign in_take   = in_valid && !in_stall;
  assign res       = (step_length == '0) ? LW'(1) : step_length;
  assign fail      = extend_count >= iteration_limit;
  assign scan_last = (NTW'(scan_idx) + NTW'(1)) == node_total;
  assign obs_last  = (OTW'(obs_idx) + OTW'(1)) == obs_total;
  assign steps_done = (k == steps);
  assign path_end  = (scan_idx == '0) || (pcnt == 6'(rrt_pkg::ResultCap - 1));
  assign sum2      = acc + (PW+1)'(prod);

  // square root step
  assign sq_t     = sq_r + sq_bit;
  assign sq_v_new = (sq_v >= sq_t) ? sq_v - sq_t : sq_v;
  assign sq_r_new = (sq_v >= sq_t) ? (sq_r >> 1) + sq_bit : sq_r >> 1;

  // divide step
  assign rem_sh      = {div_rem[CW:0], div_num[DB-1]};
  assign div_ge      = rem_sh >= {1'b0, div_den};
  assign div_num_new = {div_num[DB-2:0], div_ge};
  assign div_q       = div_num[CW:0];
  assign lim_steps   = (div_num > DB'(MAX_STEPS)) ? SW'(MAX_STEPS) : div_num[SW-1:0];
  assign lim_src     = (sq_r_new[CW:0] < (CW+1)'(expand_limit)) ?
                       sq_r_new[CW:0] : (CW+1)'(expand_limit);

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      rrt_pkg::S_NEAR_MX: begin
        mul_a = rrt_pkg::mag(rrt_pkg::sdiff(rd_x, px)); mul_b = mul_a;
      end
      rrt_pkg::S_NEAR_MY: begin
        mul_a = rrt_pkg::mag(rrt_pkg::sdiff(rd_y, py)); mul_b = mul_a;
      end
      rrt_pkg::S_D2X: begin
        mul_a = rrt_pkg::mag(rrt_pkg::sdiff(px, bx)); mul_b = mul_a;
      end
      rrt_pkg::S_D2Y: begin
        mul_a = rrt_pkg::mag(rrt_pkg::sdiff(py, by)); mul_b = mul_a;
      end
      rrt_pkg::S_SXM: begin
        mul_a = rrt_pkg::mag(dx); mul_b = (CW+1)'(res);
      end
      rrt_pkg::S_SYM: begin
        mul_a = rrt_pkg::mag(dy); mul_b = (CW+1)'(res);
      end
      rrt_pkg::S_OB_MX: begin
        mul_a = rrt_pkg::mag(rrt_pkg::sdiff(cx, ob_x)); mul_b = mul_a;
      end
      rrt_pkg::S_OB_MY: begin
        mul_a = rrt_pkg::mag(rrt_pkg::sdiff(cy, ob_y)); mul_b = mul_a;
      end
      rrt_pkg::S_OB_MR: begin
        mul_a = (CW+1)'(ob_r); mul_b = mul_a;
      end
      rrt_pkg::S_G2X: begin
        mul_a = rrt_pkg::mag(rrt_pkg::sdiff(cx, goal_x)); mul_b = mul_a;
      end
      rrt_pkg::S_G2Y: begin
        mul_a = rrt_pkg::mag(rrt_pkg::sdiff(cy, goal_y)); mul_b = mul_a;
      end
      rrt_pkg::S_G2R: begin
        mul_a = (CW+1)'(expand_limit); mul_b = mul_a;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // next state and result selection
  always_comb begin
    state_next = state;
    emit   = 1'b0;
    e_st   = rrt_pkg::ST_ACK;
    e_x    = '0;
    e_y    = '0;
    e_last = 1'b1;
    unique case (state)
      rrt_pkg::S_IDLE: begin
        if (in_take) begin
          unique case (rrt_pkg::req_t'(req_type))
            rrt_pkg::REQ_CLEAR, rrt_pkg::REQ_RESTART: emit = 1'b1;
            rrt_pkg::REQ_APPEND: begin
              emit = 1'b1;
              if (obs_total == OTW'(MAX_OBSTACLES)) e_st = rrt_pkg::ST_FULL;
            end
            rrt_pkg::REQ_EXTEND: begin
              if (plan_finished || node_total == '0) begin
                emit = 1'b1;
                e_st = rrt_pkg::ST_FINISHED;
              end else begin
                state_next = rrt_pkg::S_NEAR_RD;
              end
            end
          endcase
        end
      end
      rrt_pkg::S_NEAR_RD:  state_next = rrt_pkg::S_NEAR_MX;
      rrt_pkg::S_NEAR_MX:  state_next = rrt_pkg::S_NEAR_MY;
      rrt_pkg::S_NEAR_MY:  state_next = rrt_pkg::S_NEAR_CMP;
      rrt_pkg::S_NEAR_CMP: state_next = scan_last ? rrt_pkg::S_D2X : rrt_pkg::S_NEAR_RD;
      rrt_pkg::S_D2X:      state_next = rrt_pkg::S_D2Y;
      rrt_pkg::S_D2Y:      state_next = rrt_pkg::S_D2S;
      rrt_pkg::S_D2S:      state_next = rrt_pkg::S_SQRT;
      rrt_pkg::S_SQRT: begin
        if (cnt == CNW'(rrt_pkg::SqIters - 1)) state_next = rrt_pkg::S_DIVL;
      end
      rrt_pkg::S_DIVL: begin
        if (cnt == CNW'(DB - 1)) state_next = rrt_pkg::S_LIM;
      end
      rrt_pkg::S_LIM: begin
        state_next = (lim_steps == '0) ? rrt_pkg::S_DECIDE : rrt_pkg::S_SXM;
      end
      rrt_pkg::S_SXM: state_next = rrt_pkg::S_SXL;
      rrt_pkg::S_SXL: state_next = rrt_pkg::S_DIVX;
      rrt_pkg::S_DIVX: begin
        if (cnt == CNW'(DB - 1)) state_next = rrt_pkg::S_SYM;
      end
      rrt_pkg::S_SYM: state_next = rrt_pkg::S_SYL;
      rrt_pkg::S_SYL: state_next = rrt_pkg::S_DIVY;
      rrt_pkg::S_DIVY: begin
        if (cnt == CNW'(DB - 1)) state_next = rrt_pkg::S_SFIN;
      end
      rrt_pkg::S_SFIN: state_next = rrt_pkg::S_STEP;
      rrt_pkg::S_STEP: begin
        if (!blocked && obs_total != '0) begin
          state_next = rrt_pkg::S_OB_RD;
        end else if ((k + SW'(1)) == steps) begin
          state_next = rrt_pkg::S_DECIDE;
        end else begin
          state_next = rrt_pkg::S_STEP;
        end
      end
      rrt_pkg::S_OB_RD: state_next = rrt_pkg::S_OB_MX;
      rrt_pkg::S_OB_MX: state_next = rrt_pkg::S_OB_MY;
      rrt_pkg::S_OB_MY: state_next = rrt_pkg::S_OB_MR;
      rrt_pkg::S_OB_MR: state_next = rrt_pkg::S_OB_CMP;
      rrt_pkg::S_OB_CMP: begin
        if (acc < (PW+1)'(prod) || obs_last) begin
          state_next = steps_done ? rrt_pkg::S_DECIDE : rrt_pkg::S_STEP;
        end else begin
          state_next = rrt_pkg::S_OB_RD;
        end
      end
      rrt_pkg::S_DECIDE: begin
        if (blocked || node_total >= NTW'(MAX_NODES)) begin
          if (out_free) begin
            emit   = 1'b1;
            e_st   = blocked ? rrt_pkg::ST_REJECT : rrt_pkg::ST_FULL;
            e_x    = cx;
            e_y    = cy;
            e_last = !fail;
            state_next = fail ? rrt_pkg::S_FAIL : rrt_pkg::S_IDLE;
          end
        end else begin
          state_next = rrt_pkg::S_G2X;
        end
      end
      rrt_pkg::S_G2X: state_next = rrt_pkg::S_G2Y;
      rrt_pkg::S_G2Y: state_next = rrt_pkg::S_G2R;
      rrt_pkg::S_G2R: state_next = rrt_pkg::S_G2CMP;
      rrt_pkg::S_G2CMP: begin
        if (acc <= (PW+1)'(prod)) begin
          state_next = rrt_pkg::S_PATH_RD;
        end else if (out_free) begin
          emit   = 1'b1;
          e_st   = rrt_pkg::ST_ADDED;
          e_x    = cx;
          e_y    = cy;
          e_last = !fail;
          state_next = fail ? rrt_pkg::S_FAIL : rrt_pkg::S_IDLE;
        end
      end
      rrt_pkg::S_FAIL: begin
        if (out_free) begin
          emit = 1'b1;
          e_st = rrt_pkg::ST_FAILED;
          state_next = rrt_pkg::S_IDLE;
        end
      end
      rrt_pkg::S_PATH_RD: state_next = rrt_pkg::S_PATH_OUT;
      rrt_pkg::S_PATH_OUT: begin
        if (out_free) begin
          emit   = 1'b1;
          e_st   = rrt_pkg::ST_PATH;
          e_x    = rd_x;
          e_y    = rd_y;
          e_last = path_end;
          state_next = path_end ? rrt_pkg::S_IDLE : rrt_pkg::S_PATH_RD;
        end
      end
      default: state_next = rrt_pkg::S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rrt_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      start_x         <= '0;
      start_y         <= '0;
      goal_x          <= '0;
      goal_y          <= '0;
      expand_limit    <= LW'(256);
      step_length     <= LW'(64);
      iteration_limit <= 6'd63;
    end else if (cfg_we) begin
      case (cfg_index)
        rrt_pkg::CFG_START_X:  start_x         <= cfg_data;
        rrt_pkg::CFG_START_Y:  start_y         <= cfg_data;
        rrt_pkg::CFG_GOAL_X:   goal_x          <= cfg_data;
        rrt_pkg::CFG_GOAL_Y:   goal_y          <= cfg_data;
        rrt_pkg::CFG_EXPAND:   expand_limit    <= cfg_data[LW-1:0];
        rrt_pkg::CFG_STEP_LEN: step_length     <= cfg_data[LW-1:0];
        rrt_pkg::CFG_ITER_LIM: iteration_limit <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // table reads, registered
  always_ff @(posedge clk) begin
    rd_x   <= node_x[scan_idx];
    rd_y   <= node_y[scan_idx];
    rd_par <= node_par[scan_idx];
    ob_x   <= obs_x[obs_idx];
    ob_y   <= obs_y[obs_idx];
    ob_r   <= obs_r[obs_idx];
  end

  // table writes
  always_ff @(posedge clk) begin
    if (state == rrt_pkg::S_IDLE && in_take) begin
      if (rrt_pkg::req_t'(req_type) == rrt_pkg::REQ_APPEND &&
          obs_total != OTW'(MAX_OBSTACLES)) begin
        obs_x[obs_total[OIW-1:0]] <= point_x;
        obs_y[obs_total[OIW-1:0]] <= point_y;
        obs_r[obs_total[OIW-1:0]] <= radius;
      end
      if (rrt_pkg::req_t'(req_type) == rrt_pkg::REQ_RESTART) begin
        node_x[0]   <= start_x;
        node_y[0]   <= start_y;
        node_par[0] <= '0;
      end
    end
    if (state == rrt_pkg::S_DECIDE && !blocked && node_total < NTW'(MAX_NODES)) begin
      node_x[node_total[NIW-1:0]]   <= cx;
      node_y[node_total[NIW-1:0]]   <= cy;
      node_par[node_total[NIW-1:0]] <= near_idx;
    end
  end

  // planner control state
  always_ff @(posedge clk) begin
    if (rst) begin
      node_total    <= '0;
      obs_total     <= '0;
      extend_count  <= '0;
      plan_finished <= 1'b1;
    end else begin
      if (state == rrt_pkg::S_IDLE && in_take) begin
        unique case (rrt_pkg::req_t'(req_type))
          rrt_pkg::REQ_CLEAR: obs_total <= '0;
          rrt_pkg::REQ_APPEND: begin
            if (obs_total != OTW'(MAX_OBSTACLES)) obs_total <= obs_total + OTW'(1);
          end
          rrt_pkg::REQ_RESTART: begin
            node_total    <= NTW'(1);
            extend_count  <= '0;
            plan_finished <= 1'b0;
          end
          rrt_pkg::REQ_EXTEND: begin
            if (!plan_finished && node_total != '0 && extend_count != 6'd63) begin
              extend_count <= extend_count + 6'd1;
            end
          end
        endcase
      end
      if (state == rrt_pkg::S_DECIDE && !blocked && node_total < NTW'(MAX_NODES)) begin
        node_total <= node_total + NTW'(1);
      end
      if (state == rrt_pkg::S_G2CMP && acc <= (PW+1)'(prod)) plan_finished <= 1'b1;
      if (state == rrt_pkg::S_FAIL && out_free) plan_finished <= 1'b1;
    end
  end

  // shared arithmetic datapath
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    unique case (state)
      rrt_pkg::S_IDLE: begin
        px       <= point_x;
        py       <= point_y;
        scan_idx <= '0;
        blocked  <= 1'b0;
        k        <= '0;
      end
      rrt_pkg::S_NEAR_MY, rrt_pkg::S_D2Y, rrt_pkg::S_OB_MY,
      rrt_pkg::S_G2Y: acc <= (PW+1)'(prod);
      rrt_pkg::S_OB_MR: acc <= sum2;
      rrt_pkg::S_G2R:   acc <= sum2;
      rrt_pkg::S_NEAR_CMP: begin
        if (scan_idx == '0 || sum2 < best) begin
          best     <= sum2;
          near_idx <= scan_idx;
          bx       <= rd_x;
          by       <= rd_y;
        end
        if (!scan_last) scan_idx <= scan_idx + NIW'(1);
      end
      rrt_pkg::S_D2X: begin
        dx <= rrt_pkg::sdiff(px, bx);
        dy <= rrt_pkg::sdiff(py, by);
      end
      rrt_pkg::S_D2S: begin
        sq_v   <= sum2[PW-1:0];
        sq_r   <= '0;
        sq_bit <= PW'(1) << (PW - 2);
        cnt    <= '0;
      end
      rrt_pkg::S_SQRT: begin
        sq_v   <= sq_v_new;
        sq_r   <= sq_r_new;
        sq_bit <= sq_bit >> 2;
        cnt    <= cnt + CNW'(1);
        if (cnt == CNW'(rrt_pkg::SqIters - 1)) begin
          d_val   <= sq_r_new[CW:0];
          div_num <= DB'(lim_src);
          div_rem <= '0;
          div_den <= (CW+1)'(res);
          cnt     <= '0;
        end
      end
      rrt_pkg::S_DIVL, rrt_pkg::S_DIVX, rrt_pkg::S_DIVY: begin
        div_num <= div_num_new;
        div_rem <= div_ge ? rem_sh - {1'b0, div_den} : rem_sh;
        cnt     <= cnt + CNW'(1);
      end
      rrt_pkg::S_LIM: begin
        steps <= lim_steps;
        cx    <= bx;
        cy    <= by;
      end
      rrt_pkg::S_SXL, rrt_pkg::S_SYL: begin
        div_num <= DB'(prod) + DB'(d_val >> 1);
        div_rem <= '0;
        div_den <= d_val;
        cnt     <= '0;
      end
      rrt_pkg::S_SYM:  sx <= dx[CW] ? -signed'(div_q) : signed'(div_q);
      rrt_pkg::S_SFIN: sy <= dy[CW] ? -signed'(div_q) : signed'(div_q);
      rrt_pkg::S_STEP: begin
        cx      <= rrt_pkg::sat({cx[CW-1], cx[CW-1], cx} + {sx[CW], sx});
        cy      <= rrt_pkg::sat({cy[CW-1], cy[CW-1], cy} + {sy[CW], sy});
        k       <= k + SW'(1);
        obs_idx <= '0;
      end
      rrt_pkg::S_OB_CMP: begin
        if (acc < (PW+1)'(prod)) blocked <= 1'b1;
        obs_idx <= obs_idx + OIW'(1);
      end
      rrt_pkg::S_G2CMP: begin
        scan_idx <= node_total[NIW-1:0] - NIW'(1);
        pcnt     <= '0;
      end
      rrt_pkg::S_PATH_OUT: begin
        if (out_free && !path_end) begin
          scan_idx <= rd_par;
          pcnt     <= pcnt + 6'd1;
        end
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_status <= e_st;
      out_xr     <= e_x;
      out_yr     <= e_y;
      out_last   <= e_last;
    end
  end

  assign status = out_status;
  assign out_x  = out_xr;
  assign out_y  = out_yr;
  assign last   = out_last;

  // checks
  a_node_bound: assert property (@(posedge clk) disable iff (rst)
    node_total <= NTW'(MAX_NODES))
    else $error("node count beyond table");

  a_obs_bound: assert property (@(posedge clk) disable iff (rst)
    obs_total <= OTW'(MAX_OBSTACLES))
    else $error("obstacle count beyond table");

  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    state != rrt_pkg::S_IDLE |-> in_stall)
    else $error("request taken while busy");

  a_fail_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status == rrt_pkg::ST_FAILED |-> out_last)
    else $error("failed result without last");

endmodule

// File: verif/rrt_tree_extend_2d_core_chk.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rrt_tree_extend_2d_core_chk
// Watches the register port and both channels of the tree extension block,
// keeps its own copy of the tree, obstacles and registers, and checks every
// result transfer against the oldest predicted result.
// ----------------------------------------------------------------------------
module rrt_tree_extend_2d_core_chk (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [23:0] point_x,
  input  logic [23:0] point_y,
  input  logic [22:0] radius,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  status,
  input  logic [23:0] out_x,
  input  logic [23:0] out_y,
  input  logic        last,
  output int          errors,
  output int          pending
);

  localparam int NodeCap = rrt_pkg::MaxNodesDef;
  localparam int ObsCap  = rrt_pkg::MaxObstaclesDef;
  localparam int StepCap = rrt_pkg::MaxStepsDef;

  typedef struct {
    rrt_pkg::status_t st;
    logic [23:0]      x;
    logic [23:0]      y;
    logic             lst;
  } tree_result_t;

  tree_result_t planned_q[$];

  // mirrored registers
  logic [23:0] start_x_r, start_y_r, goal_x_r, goal_y_r;
  logic [22:0] expand_r, step_r;
  logic [5:0]  iter_lim_r;

  // mirrored tree and obstacle tables
  longint node_x [NodeCap];
  longint node_y [NodeCap];
  int     node_par [NodeCap];
  int     node_cnt;
  longint obs_x [ObsCap];
  longint obs_y [ObsCap];
  longint obs_r [ObsCap];
  int     obs_cnt;
  int     ext_cnt;
  bit     plan_done;

  function automatic longint sq(input longint d);
    return d * d;
  endfunction

  // floor square root, bit by bit
  function automatic longint root_floor(input longint v);
    longint r;
    longint b;
    r = 0;
    b = longint'(1) << 62;
    while (b > v) b = b >>> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  // divide rounding halves away from zero
  function automatic longint round_div(input longint num, input longint den);
    longint m;
    longint q;
    m = (num < 0) ? -num : num;
    q = (m + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic longint clamp24(input longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  function automatic bit inside_obstacle(input longint px, input longint py);
    for (int o = 0; o < obs_cnt; o++) begin
      if (sq(px - obs_x[o]) + sq(py - obs_y[o]) < obs_r[o] * obs_r[o]) return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic plan_result(input rrt_pkg::status_t st, input longint x, input longint y,
                             input logic lst);
    tree_result_t r;
    r.st = st;
    r.x = x[23:0];
    r.y = y[23:0];
    r.lst = lst;
    planned_q = {planned_q, r};
  endtask

  // predicted results of one request
  task automatic grow_tree(input rrt_pkg::req_t rq, input logic [23:0] pxb,
                           input logic [23:0] pyb, input logic [22:0] rad);
    longint px, py, cx, cy, dx, dy, sx, sy, best, d2, g2, res, span_len, lim, el;
    int near_i, steps, idx, n;
    bit blocked, fin;
    px = $signed(pxb);
    py = $signed(pyb);
    case (rq)
      rrt_pkg::REQ_CLEAR: begin
        obs_cnt = 0;
        plan_result(rrt_pkg::ST_ACK, 0, 0, 1'b1);
      end
      rrt_pkg::REQ_APPEND: begin
        if (obs_cnt >= ObsCap) begin
          plan_result(rrt_pkg::ST_FULL, 0, 0, 1'b1);
        end else begin
          obs_x[obs_cnt] = px;
          obs_y[obs_cnt] = py;
          obs_r[obs_cnt] = longint'(rad);
          obs_cnt++;
          plan_result(rrt_pkg::ST_ACK, 0, 0, 1'b1);
        end
      end
      rrt_pkg::REQ_RESTART: begin
        node_x[0] = $signed(start_x_r);
        node_y[0] = $signed(start_y_r);
        node_par[0] = 0;
        node_cnt = 1;
        ext_cnt = 0;
        plan_done = 1'b0;
        plan_result(rrt_pkg::ST_ACK, 0, 0, 1'b1);
      end
      default: begin
        if (plan_done || node_cnt == 0) begin
          plan_result(rrt_pkg::ST_FINISHED, 0, 0, 1'b1);
          return;
        end
        ext_cnt = (ext_cnt + 1) & 63;
        if (ext_cnt == 0) ext_cnt = 63;
        // nearest node, first one wins a tie
        near_i = 0;
        best = 0;
        for (int i = 0; i < node_cnt; i++) begin
          d2 = sq(node_x[i] - px) + sq(node_y[i] - py);
          if (i == 0 || d2 < best) begin
            best = d2;
            near_i = i;
          end
        end
        cx = node_x[near_i];
        cy = node_y[near_i];
        dx = px - cx;
        dy = py - cy;
        // steering
        res = (step_r == 0) ? 1 : longint'(step_r);
        el = longint'(expand_r);
        span_len = root_floor(sq(dx) + sq(dy));
        lim = span_len / res;
        if (el / res < lim) lim = el / res;
        if (lim > StepCap) lim = StepCap;
        steps = int'(lim);
        sx = 0;
        sy = 0;
        if (steps > 0) begin
          sx = round_div(dx * res, span_len);
          sy = round_div(dy * res, span_len);
        end
        blocked = 1'b0;
        for (int k = 0; k < steps; k++) begin
          cx = clamp24(cx + sx);
          cy = clamp24(cy + sy);
          if (inside_obstacle(cx, cy)) blocked = 1'b1;
        end
        if (blocked) begin
          plan_result(rrt_pkg::ST_REJECT, cx, cy, 1'b0);
        end else if (node_cnt >= NodeCap) begin
          plan_result(rrt_pkg::ST_FULL, cx, cy, 1'b0);
        end else begin
          idx = node_cnt;
          g2 = sq(cx - longint'($signed(goal_x_r))) + sq(cy - longint'($signed(goal_y_r)));
          node_x[idx] = cx;
          node_y[idx] = cy;
          node_par[idx] = near_i;
          node_cnt++;
          if (g2 <= el * el) begin
            // goal reached: walk back to the start
            plan_done = 1'b1;
            n = 0;
            while (1) begin
              fin = (idx == 0) || (n == rrt_pkg::ResultCap - 1);
              plan_result(rrt_pkg::ST_PATH, node_x[idx], node_y[idx], fin);
              n++;
              if (fin) return;
              idx = node_par[idx];
            end
          end
          plan_result(rrt_pkg::ST_ADDED, cx, cy, 1'b0);
        end
        if (ext_cnt >= int'(iter_lim_r)) begin
          plan_done = 1'b1;
          plan_result(rrt_pkg::ST_FAILED, 0, 0, 1'b1);
        end else begin
          planned_q[$].lst = 1'b1;
        end
      end
    endcase
  endtask

  // compare result transfers, then track register writes and request transfers
  always @(posedge clk) begin
    tree_result_t e;
    if (rst) begin
      planned_q.delete();
      start_x_r <= 24'd0;
      start_y_r <= 24'd0;
      goal_x_r <= 24'd0;
      goal_y_r <= 24'd0;
      expand_r <= 23'd256;
      step_r <= 23'd64;
      iter_lim_r <= 6'd63;
      node_cnt = 0;
      obs_cnt = 0;
      ext_cnt = 0;
      plan_done = 1'b1;
    end else begin
      if (out_valid && !out_stall) begin
        if (planned_q.size() == 0) begin
          $display("%0t: unexpected result status=%0d x=%0d y=%0d last=%0d", $time,
                   status, $signed(out_x), $signed(out_y), last);
          errors++;
        end else begin
          e = planned_q.pop_front();
          if (status !== e.st || out_x !== e.x || out_y !== e.y || last !== e.lst) begin
            $display({"%0t: mismatch expected st=%0d x=%0d y=%0d last=%0d",
                      " actual st=%0d x=%0d y=%0d last=%0d"},
                     $time, e.st, $signed(e.x), $signed(e.y), e.lst,
                     status, $signed(out_x), $signed(out_y), last);
            errors++;
          end
        end
      end
      if (cfg_we) begin
        case (rrt_pkg::cfg_reg_t'(cfg_index))
          rrt_pkg::CFG_START_X:  start_x_r <= cfg_data;
          rrt_pkg::CFG_START_Y:  start_y_r <= cfg_data;
          rrt_pkg::CFG_GOAL_X:   goal_x_r <= cfg_data;
          rrt_pkg::CFG_GOAL_Y:   goal_y_r <= cfg_data;
          rrt_pkg::CFG_EXPAND:   expand_r <= cfg_data[22:0];
          rrt_pkg::CFG_STEP_LEN: step_r <= cfg_data[22:0];
          rrt_pkg::CFG_ITER_LIM: iter_lim_r <= cfg_data[5:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        grow_tree(rrt_pkg::req_t'(req_type), point_x, point_y, radius);
      end
    end
    pending = planned_q.size();
  end

endmodule

// File: verif/rrt_tree_extend_2d_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rrt_tree_extend_2d_core_tb
// Drives register settings and request streams into the tree extension block
// (directed cases, a long straight chain, then random planning rounds) under
// random sender gaps and receiver stalls; the checker predicts and compares.
// ----------------------------------------------------------------------------
module rrt_tree_extend_2d_core_tb;

  localparam int ItemTarget = 420;
  localparam int QuietLimit = 20000;
  localparam int HoldCycles = 400;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = 3'd0;
  logic [23:0] cfg_data = 24'd0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  req_type = 2'd0;
  logic [23:0] point_x = 24'd0;
  logic [23:0] point_y = 24'd0;
  logic [22:0] radius = 23'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  status;
  logic [23:0] out_x;
  logic [23:0] out_y;
  logic        last;

  int errors;
  int pending;
  int items_sent = 0;
  int burst_left = 0;
  int quiet = 0;
  bit hold_req = 1'b0;
  bit hold_seen = 1'b0;
  int hold_left = 0;
  int stall_mode = 0;
  int mode_cycles = 0;

  rrt_tree_extend_2d_core dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .req_type(req_type),
    .point_x(point_x), .point_y(point_y), .radius(radius),
    .out_valid(out_valid), .out_stall(out_stall), .status(status),
    .out_x(out_x), .out_y(out_y), .last(last)
  );

  rrt_tree_extend_2d_core_chk chk (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .req_type(req_type),
    .point_x(point_x), .point_y(point_y), .radius(radius),
    .out_valid(out_valid), .out_stall(out_stall), .status(status),
    .out_x(out_x), .out_y(out_y), .last(last),
    .errors(errors), .pending(pending)
  );

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // receiver: long hold-off on request, otherwise a changing stall pattern
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HoldCycles;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      if (mode_cycles == 0) begin
        stall_mode <= $urandom_range(0, 3);
        mode_cycles <= $urandom_range(50, 300);
      end else begin
        mode_cycles <= mode_cycles - 1;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 9) < 3);
        2: out_stall <= (mode_cycles % 3 == 0);
        default: out_stall <= ($urandom_range(0, 9) < 7);
      endcase
    end
  end

  // watchdog on cycles with no transfer
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= QuietLimit) begin
        $display("rrt_tree_extend_2d_core_tb: FAIL");
        $finish;
      end
    end
  end

  // one request transfer, then maybe a gap between bursts
  task automatic send_req(input rrt_pkg::req_t rq, input logic [23:0] x,
                          input logic [23:0] y, input logic [22:0] r);
    int gap;
    in_valid <= 1'b1;
    req_type <= rq;
    point_x <= x;
    point_y <= y;
    radius <= r;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  // stop sending until every predicted result has come back
  task automatic wait_drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input rrt_pkg::cfg_reg_t idx, input logic [23:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic load_config(input logic [23:0] sx, input logic [23:0] sy,
                             input logic [23:0] gx, input logic [23:0] gy,
                             input logic [22:0] el, input logic [22:0] sl,
                             input logic [5:0] il);
    write_reg(rrt_pkg::CFG_START_X, sx);
    write_reg(rrt_pkg::CFG_START_Y, sy);
    write_reg(rrt_pkg::CFG_GOAL_X, gx);
    write_reg(rrt_pkg::CFG_GOAL_Y, gy);
    write_reg(rrt_pkg::CFG_EXPAND, {1'b0, el});
    write_reg(rrt_pkg::CFG_STEP_LEN, {1'b0, sl});
    write_reg(rrt_pkg::CFG_ITER_LIM, {18'd0, il});
    cfg_we <= 1'b0;
  endtask

  function automatic logic [23:0] near_pt(input logic [23:0] base, input int span);
    return base + 24'($urandom_range(0, 2 * span)) - 24'(span);
  endfunction

  initial begin
    logic [23:0] sx, sy, gx, gy;
    logic [22:0] el, sl;
    logic [5:0]  il;
    int kind, rounds, nobs, nsamp, pick;
    bit held;
    held = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: finished before restart, obstacles, zero steps, limit reached
    send_req(rrt_pkg::REQ_EXTEND, 24'd100, 24'd100, 23'd0);
    wait_drain();
    load_config(-24'sd1024, 24'd0, 24'd2048, 24'd0, 23'd256, 23'd64, 6'd4);
    send_req(rrt_pkg::REQ_EXTEND, 24'd5, 24'd5, 23'd0);
    send_req(rrt_pkg::REQ_RESTART, 24'd0, 24'd0, 23'd0);
    send_req(rrt_pkg::REQ_APPEND, 24'd0, 24'd0, 23'd128);
    send_req(rrt_pkg::REQ_APPEND, 24'h7FFFFF, 24'h800000, 23'h7FFFFF);
    send_req(rrt_pkg::REQ_APPEND, 24'd300, 24'd300, 23'd0);
    send_req(rrt_pkg::REQ_EXTEND, -24'sd1024, 24'd0, 23'd0);
    send_req(rrt_pkg::REQ_EXTEND, 24'd0, 24'd0, 23'd0);
    send_req(rrt_pkg::REQ_EXTEND, 24'h7FFFFF, 24'd0, 23'd0);
    send_req(rrt_pkg::REQ_EXTEND, 24'h800000, 24'h800000, 23'd0);
    send_req(rrt_pkg::REQ_EXTEND, 24'd0, 24'd0, 23'd0);
    send_req(rrt_pkg::REQ_CLEAR, 24'hFFFFFF, 24'hFFFFFF, 23'h7FFFFF);
    send_req(rrt_pkg::REQ_RESTART, 24'd0, 24'd0, 23'd0);
    send_req(rrt_pkg::REQ_APPEND, -24'sd600, 24'd0, 23'd100);
    send_req(rrt_pkg::REQ_EXTEND, 24'd0, 24'd0, 23'd0);
    send_req(rrt_pkg::REQ_EXTEND, 24'd2048, 24'd0, 23'd0);
    send_req(rrt_pkg::REQ_EXTEND, 24'd2048, 24'd100, 23'd0);
    send_req(rrt_pkg::REQ_CLEAR, 24'd0, 24'd0, 23'd0);
    wait_drain();

    // straight chain to the goal: longest path readout, with a long hold-off
    load_config(24'd0, 24'd0, 24'd4096, 24'd0, 23'd64, 23'd64, 6'd63);
    send_req(rrt_pkg::REQ_RESTART, 24'd0, 24'd0, 23'd0);
    hold_req <= ~hold_req;
    repeat (63) send_req(rrt_pkg::REQ_EXTEND, 24'd1000000, 24'd0, 23'd0);
    wait_drain();

    // random planning rounds
    while (items_sent < ItemTarget) begin
      kind = $urandom_range(0, 9);
      sx = near_pt(24'd0, 8192);
      sy = near_pt(24'd0, 8192);
      gx = near_pt(sx, 3072);
      gy = near_pt(sy, 3072);
      sl = 23'($urandom_range(32, 256));
      el = 23'(int'(sl) * int'($urandom_range(1, 8)));
      il = 6'($urandom_range(1, 63));
      case (kind)
        0: begin
          sx = 24'h7FFFFF; sy = 24'h7FFFFF; gx = 24'h800000; gy = 24'h800000;
          el = 23'h7FFFFF; sl = 23'h7FFFFF; il = 6'd63;
        end
        1: begin
          sx = 24'h800000; sy = 24'h800000; gx = 24'h7FFFFF; gy = 24'h7FFFFF;
          el = 23'd1; sl = 23'd1; il = 6'd1;
        end
        2: begin
          sl = 23'd0; el = 23'($urandom_range(0, 64)); il = 6'd0;
        end
        default: ;
      endcase
      wait_drain();
      load_config(sx, sy, gx, gy, el, sl, il);
      if (!held && kind > 3) begin
        held = 1'b1;
        hold_req <= ~hold_req;
      end
      rounds = $urandom_range(1, 3);
      repeat (rounds) begin
        send_req(rrt_pkg::REQ_RESTART, 24'($urandom), 24'($urandom), 23'($urandom));
        if (kind == 3) begin
          // overfill the obstacle table, probe a little, then empty it
          repeat (17) send_req(rrt_pkg::REQ_APPEND, near_pt(gx, 30000),
                               near_pt(gy, 30000), 23'($urandom_range(0, 300)));
          repeat (3) send_req(rrt_pkg::REQ_EXTEND, near_pt(gx, 1024), near_pt(gy, 1024),
                              23'd0);
          send_req(rrt_pkg::REQ_CLEAR, 24'($urandom), 24'($urandom), 23'($urandom));
        end else begin
          nobs = $urandom_range(0, 3);
          repeat (nobs) send_req(rrt_pkg::REQ_APPEND,
                                 near_pt((sx >>> 1) + (gx >>> 1), 1536),
                                 near_pt((sy >>> 1) + (gy >>> 1), 1536),
                                 23'($urandom_range(0, 512)));
          nsamp = $urandom_range(4, 30);
          repeat (nsamp) begin
            pick = $urandom_range(0, 99);
            if (pick < 45 || kind < 2)
              send_req(rrt_pkg::REQ_EXTEND, near_pt(gx, 4096), near_pt(gy, 4096),
                       23'($urandom));
            else if (pick < 80)
              send_req(rrt_pkg::REQ_EXTEND, near_pt(sx, 4096), near_pt(sy, 4096),
                       23'($urandom));
            else if (pick < 90)
              send_req(rrt_pkg::REQ_EXTEND, 24'($urandom), 24'($urandom), 23'($urandom));
            else
              send_req(rrt_pkg::req_t'($urandom_range(0, 2)), 24'($urandom),
                       24'($urandom), 23'($urandom));
          end
        end
      end
    end

    wait_drain();
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("rrt_tree_extend_2d_core_tb: PASS");
    end else begin
      $display("rrt_tree_extend_2d_core_tb: FAIL");
    end
    $finish;
  end

endmodule
